### rtl/mrkx_pkg.sv
// Package for the MD5 rolling-key XOR cipher.
// Holds the sequencer state type, the core status struct and the MD5 round tables.
// No dependencies.
package mrkx_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned ROUND_W   = 6;
    localparam int unsigned ADDR_W    = 3;
    localparam int unsigned LAST_ROUND = 63;

    localparam logic [WORD_W-1:0] MD_A0 = 32'h6745_2301;
    localparam logic [WORD_W-1:0] MD_B0 = 32'hefcd_ab89;
    localparam logic [WORD_W-1:0] MD_C0 = 32'h98ba_dcfe;
    localparam logic [WORD_W-1:0] MD_D0 = 32'h1032_5476;

    // Fixed message words of the padded block for a four-byte message.
    localparam logic [WORD_W-1:0] PAD_MARK = 32'h0000_0080;
    localparam logic [WORD_W-1:0] MSG_BITS = 32'h0000_0020;
    localparam logic [3:0] G_KEY  = 4'd0;
    localparam logic [3:0] G_PAD  = 4'd1;
    localparam logic [3:0] G_LEN  = 4'd14;

    localparam logic [ADDR_W-3:0] REG_INITIAL_KEY = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_status;

    function automatic logic [WORD_W-1:0] md_k(input logic [ROUND_W-1:0] i);
        logic [WORD_W-1:0] k;
        unique case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md_s(input logic [ROUND_W-1:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word index; all products wrap at four bits.
    function automatic logic [3:0] md_g(input logic [ROUND_W-1:0] i);
        logic [3:0] n;
        logic [3:0] g;
        n = i[3:0];
        unique case (i[5:4])
            2'd0: g = n;
            2'd1: g = 4'((n << 2) + n + 4'd1);
            2'd2: g = 4'((n << 1) + n + 4'd5);
            2'd3: g = 4'((n << 3) - n);
            default: g = n;
        endcase
        return g;
    endfunction

endpackage

### rtl/mrkx_md5_core.sv
// Iterative MD5 core: one shared round datapath run 64 times under a small sequencer.
// Produces the final chaining word D of MD5 over a four-byte message. Uses mrkx_pkg.
module mrkx_md5_core
    import mrkx_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [WORD_W-1:0]   i_key,
    output t_core_status        o_status,
    output logic [WORD_W-1:0]   o_tail
);

    t_state              r_state, n_state;
    logic [ROUND_W-1:0]  r_round;
    logic [WORD_W-1:0]   r_a, r_b, r_c, r_d, r_msg, r_tail;

    logic [WORD_W-1:0]   f_val, m_val, sum, rot;
    logic [3:0]          g_idx;
    logic [4:0]          s_amt;
    logic [2*WORD_W-1:0] rot_wide;

    always_comb begin
        unique case (r_round[5:4])
            2'd0: f_val = (r_b & r_c) | (~r_b & r_d);
            2'd1: f_val = (r_d & r_b) | (~r_d & r_c);
            2'd2: f_val = r_b ^ r_c ^ r_d;
            2'd3: f_val = r_c ^ (r_b | ~r_d);
            default: f_val = '0;
        endcase
        g_idx = md_g(r_round);
        case (g_idx)
            G_KEY:   m_val = r_msg;
            G_PAD:   m_val = PAD_MARK;
            G_LEN:   m_val = MSG_BITS;
            default: m_val = '0;
        endcase
        s_amt    = md_s(r_round);
        sum      = r_a + f_val + md_k(r_round) + m_val;
        // The shift amount is never zero, so the wide shift gives the rotation.
        rot_wide = {sum, sum} >> (6'(WORD_W) - {1'b0, s_amt});
        rot      = rot_wide[WORD_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_ROUND;
            ST_ROUND: if (r_round == ROUND_W'(LAST_ROUND)) n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_ROUND) begin
                r_round <= r_round + 1'b1;
            end else begin
                r_round <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_a   <= MD_A0;
            r_b   <= MD_B0;
            r_c   <= MD_C0;
            r_d   <= MD_D0;
            r_msg <= i_key;
        end else if (r_state == ST_ROUND) begin
            r_a <= r_d;
            r_b <= r_b + rot;
            r_c <= r_b;
            r_d <= r_c;
            // After the last round the new D is the current C.
            if (r_round == ROUND_W'(LAST_ROUND)) begin
                r_tail <= MD_D0 + r_c;
            end
        end
    end

    assign o_status.busy = (r_state != ST_IDLE);
    assign o_status.done = (r_state == ST_DONE);
    assign o_tail        = r_tail;

endmodule

### rtl/md5_rolling_key_xor_cipher_top.sv
// Top level of the MD5 rolling-key XOR cipher: APB key register, rolling key, output register.
// Instantiates mrkx_md5_core. Uses mrkx_pkg.
//
//  Channel   Direction  Handshake                  Payload
//  input     in         i_in_valid / o_in_stall    i_plain_word, i_first_word
//  output    out        o_out_valid / i_out_stall  o_cipher_word
//  config    in         psel, penable, pwrite      paddr, pwdata, prdata
//
// A request's cipher word shows in the output register on the next cycle. The key
// update then runs 64 MD5 rounds, one per cycle in the shared round datapath, and then
// a finish state; no new request is taken until the update is done.
// A request is also held off while an earlier cipher word is stalled at the output.
// Reset is synchronous; it clears the key register, the rolling key and the control.
module md5_rolling_key_xor_cipher_top
    import mrkx_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [WORD_W-1:0]   i_plain_word,
    input  logic                i_first_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [WORD_W-1:0]   o_cipher_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [WORD_W-1:0]   pwdata,
    output logic [WORD_W-1:0]   prdata,
    output logic                pready
);

    logic [WORD_W-1:0] r_initial_key, r_rolling_key, r_cipher;
    logic              r_out_valid;
    logic [WORD_W-1:0] eff_key, core_tail;
    logic              in_accept, ready;
    t_core_status      core_status;

    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1:2] == REG_INITIAL_KEY) ? r_initial_key : '0;

    assign ready      = !core_status.busy && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !ready;
    assign in_accept  = i_in_valid && ready;
    assign eff_key    = i_first_word ? r_initial_key : r_rolling_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_key <= '0;
            r_rolling_key <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready
                && paddr[ADDR_W-1:2] == REG_INITIAL_KEY) begin
                r_initial_key <= pwdata;
            end
            if (in_accept) begin
                r_rolling_key <= eff_key;
            end else if (core_status.done) begin
                r_rolling_key <= r_rolling_key ^ core_tail;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cipher <= i_plain_word ^ eff_key;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cipher_word = r_cipher;

    mrkx_md5_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_accept),
        .i_key    (eff_key),
        .o_status (core_status),
        .o_tail   (core_tail)
    );

endmodule

### rtl/mrkx_checker.sv
// Port-level checker for the MD5 rolling-key XOR cipher, with its bind statement.
// Sees only the top-level ports. Uses mrkx_pkg.
module mrkx_checker
    import mrkx_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [WORD_W-1:0] o_cipher_word,
    input logic              pready
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // Every accepted request yields a cipher word on the following cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("no cipher word after an accepted request");

    // The key update keeps the input held off after a request.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input not held off during key update");

    a_busy_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##2 o_in_stall)
        else $error("key update ended too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cipher_word))
        else $error("stalled cipher word changed");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready dropped");

endmodule

bind md5_rolling_key_xor_cipher_top mrkx_checker u_mrkx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_cipher_word (o_cipher_word),
    .pready        (pready)
);
